// ----- hw/rtl/vruntime_ordered_run_queue_unit_macros.svh -----
// Assertion macros for the run queue unit.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef VRUNTIME_ORDERED_RUN_QUEUE_UNIT_MACROS_SVH
`define VRUNTIME_ORDERED_RUN_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/vroq_pkg.sv -----
// Shared types and constants for the run queue unit.
// No dependencies; used by vroq_cell and the top level.
package vroq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned RT_W            = 64;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned COUNT_W         = 5;

  localparam logic [ID_W-1:0] IDLE_ID_RESET = 8'd0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_NEXT   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_SEARCH = 1'b1
  } fsm_t;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_POP    = 3'd2,
    CMD_START  = 3'd3,
    CMD_SCAN   = 3'd4,
    CMD_DELETE = 3'd5,
    CMD_ABORT  = 3'd6
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t         op;
    logic [ID_W-1:0] task_id;
    logic [RT_W-1:0] runtime;
  } cell_cmd_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] task_id;
    logic [RT_W-1:0] runtime;
  } slot_t;

endpackage

// ----- hw/rtl/vroq_cell.sv -----
// One slot of the sorted run queue chain, with its search token.
// Depends on vroq_pkg for the command and slot types.
module vroq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  vroq_pkg::cell_cmd_t cmd,
  input  vroq_pkg::slot_t    left,
  input  logic               left_gt,
  input  logic               left_tok,
  input  vroq_pkg::slot_t    right,
  output vroq_pkg::slot_t    slot,
  output logic               gt,
  output logic               tok,
  output logic               hit,
  output logic               miss
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [vroq_pkg::ID_W-1:0] id_r;
  logic [vroq_pkg::ID_W-1:0] id_nxt;
  logic [vroq_pkg::RT_W-1:0] rt_r;
  logic [vroq_pkg::RT_W-1:0] rt_nxt;
  logic                      tok_r;
  logic                      tok_nxt;
  logic                      passed_r;
  logic                      passed_nxt;

  assign slot.valid   = valid_r;
  assign slot.task_id = id_r;
  assign slot.runtime = rt_r;
  assign tok          = tok_r;
  assign gt           = !valid_r || (rt_r > cmd.runtime);
  assign hit          = tok_r && valid_r && (id_r == cmd.task_id);
  assign miss         = tok_r && !valid_r;

  always_comb begin
    valid_nxt  = valid_r;
    id_nxt     = id_r;
    rt_nxt     = rt_r;
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    unique case (cmd.op)
      vroq_pkg::CMD_INSERT: begin
        if (left_gt) begin
          valid_nxt = left.valid;
          id_nxt    = left.task_id;
          rt_nxt    = left.runtime;
        end else if (gt) begin
          valid_nxt = 1'b1;
          id_nxt    = cmd.task_id;
          rt_nxt    = cmd.runtime;
        end
      end
      vroq_pkg::CMD_POP: begin
        valid_nxt = right.valid;
        id_nxt    = right.task_id;
        rt_nxt    = right.runtime;
      end
      vroq_pkg::CMD_START: begin
        tok_nxt    = left_tok;
        passed_nxt = 1'b0;
      end
      vroq_pkg::CMD_SCAN: begin
        tok_nxt    = left_tok;
        passed_nxt = passed_r || tok_r;
      end
      vroq_pkg::CMD_DELETE: begin
        if (!passed_r) begin
          valid_nxt = right.valid;
          id_nxt    = right.task_id;
          rt_nxt    = right.runtime;
        end
        tok_nxt    = 1'b0;
        passed_nxt = 1'b0;
      end
      vroq_pkg::CMD_ABORT: begin
        tok_nxt    = 1'b0;
        passed_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    rt_r <= rt_nxt;
  end

endmodule

// ----- hw/rtl/vruntime_ordered_run_queue_unit.sv -----
// Top level of the run queue unit: control, output register and the cell chain.
// Depends on vroq_pkg, vroq_cell and the assertion macro header.
//
// Usage: requests enter on the in_ channel (valid/ready) and each produces exactly
// one result on the out_ channel (valid/ready), in request order. The queue is a
// chain of QUEUE_DEPTH cells kept sorted by runtime, head in cell 0.
// Add, next and the unused code complete at the accepting edge; the result is
// shown in the following cycle, so one such request can be taken every cycle while the receiver takes each result.
// Remove sends a search token down the chain one cell per cycle; the result is
// registered when the token reaches the task, or as not found when it reaches an
// empty cell or leaves the chain. No further request is taken during a search.
// The idle task id is written through cfg_wr_en/cfg_wr_data; the user must write it while the unit is
// idle, the block itself does not enforce that; it resets to zero.
// Reset (synchronous, rst_n low) empties the queue and drops any pending result.
// When the receiver stalls, the result is held in the output register and a new
// request is only taken in the cycle in which that result leaves.
`include "vruntime_ordered_run_queue_unit_macros.svh"

module vruntime_ordered_run_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = vroq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [vroq_pkg::ID_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vroq_pkg::FUNC_W-1:0]   in_func,
  input  logic [vroq_pkg::ID_W-1:0]     in_task_id,
  input  logic [vroq_pkg::RT_W-1:0]     in_runtime_in,
  input  logic                          in_is_new,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vroq_pkg::ID_W-1:0]     out_task_out,
  output logic [vroq_pkg::RT_W-1:0]     out_runtime_out,
  output logic [vroq_pkg::STATUS_W-1:0] out_status,
  output logic [vroq_pkg::COUNT_W-1:0]  out_count
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  vroq_pkg::slot_t                slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         gt_v;
  logic [QUEUE_DEPTH-1:0]         tok_v;
  logic [QUEUE_DEPTH-1:0]         hit_v;
  logic [QUEUE_DEPTH-1:0]         miss_v;
  logic [QUEUE_DEPTH-1:0]         valid_v;
  vroq_pkg::cell_cmd_t            cmd;
  logic                           tok_in;

  vroq_pkg::fsm_t                 state_r;
  vroq_pkg::fsm_t                 state_nxt;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic [vroq_pkg::ID_W-1:0]      task_r;
  logic [vroq_pkg::ID_W-1:0]      task_nxt;
  logic [vroq_pkg::ID_W-1:0]      idle_r;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [vroq_pkg::ID_W-1:0]      out_task_r;
  logic [vroq_pkg::ID_W-1:0]      out_task_nxt;
  logic [vroq_pkg::RT_W-1:0]      out_rt_r;
  logic [vroq_pkg::RT_W-1:0]      out_rt_nxt;
  vroq_pkg::status_t              out_status_r;
  vroq_pkg::status_t              out_status_nxt;
  logic [vroq_pkg::COUNT_W-1:0]   out_count_r;
  logic [vroq_pkg::COUNT_W-1:0]   out_count_nxt;
  logic [CNT_W+vroq_pkg::COUNT_W-1:0] count_wide;

  logic                           accept;
  logic                           full;
  logic [vroq_pkg::RT_W-1:0]      head_rt;
  logic [vroq_pkg::RT_W-1:0]      add_rt;
  logic [vroq_pkg::RT_W-1:0]      hit_rt;
  logic                           hit_any;
  logic                           miss_any;
  logic                           tok_any;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    vroq_pkg::slot_t left_slot;
    vroq_pkg::slot_t right_slot;
    logic            left_gt;
    logic            left_tok;

    if (i == 0) begin : g_first
      assign left_slot = '0;
      assign left_gt   = 1'b0;
      assign left_tok  = tok_in;
    end else begin : g_inner
      assign left_slot = slots[i-1];
      assign left_gt   = gt_v[i-1];
      assign left_tok  = tok_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_more
      assign right_slot = slots[i+1];
    end

    vroq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left     (left_slot),
      .left_gt  (left_gt),
      .left_tok (left_tok),
      .right    (right_slot),
      .slot     (slots[i]),
      .gt       (gt_v[i]),
      .tok      (tok_v[i]),
      .hit      (hit_v[i]),
      .miss     (miss_v[i])
    );

    assign valid_v[i] = slots[i].valid;
  end

  assign in_ready = (state_r == vroq_pkg::FSM_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_rt  = slots[0].valid ? slots[0].runtime : '0;
  assign add_rt   = in_is_new ? in_runtime_in : head_rt;
  assign hit_any  = |hit_v;
  assign miss_any = |miss_v;
  assign tok_any  = |tok_v;
  assign tok_in   = (cmd.op == vroq_pkg::CMD_START);

  always_comb begin
    hit_rt = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_rt = hit_rt | (hit_v[i] ? slots[i].runtime : '0);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    task_nxt       = task_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_task_nxt   = out_task_r;
    out_rt_nxt     = out_rt_r;
    out_status_nxt = out_status_r;
    cmd.op         = vroq_pkg::CMD_HOLD;
    cmd.task_id    = (state_r == vroq_pkg::FSM_IDLE) ? in_task_id : task_r;
    cmd.runtime    = add_rt;
    unique case (state_r)
      vroq_pkg::FSM_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_task_nxt   = in_task_id;
          out_rt_nxt     = '0;
          out_status_nxt = vroq_pkg::STAT_OK;
          unique case (vroq_pkg::func_t'(in_func))
            vroq_pkg::FUNC_ADD: begin
              if (full) begin
                out_status_nxt = vroq_pkg::STAT_FULL;
              end else begin
                cmd.op     = vroq_pkg::CMD_INSERT;
                out_rt_nxt = add_rt;
                count_nxt  = count_r + 1'b1;
              end
            end
            vroq_pkg::FUNC_REMOVE: begin
              cmd.op        = vroq_pkg::CMD_START;
              task_nxt      = in_task_id;
              state_nxt     = vroq_pkg::FSM_SEARCH;
              out_valid_nxt = 1'b0;
            end
            vroq_pkg::FUNC_NEXT: begin
              if (count_r == '0) begin
                out_task_nxt   = idle_r;
                out_status_nxt = vroq_pkg::STAT_EMPTY;
              end else begin
                cmd.op       = vroq_pkg::CMD_POP;
                out_task_nxt = slots[0].task_id;
                out_rt_nxt   = slots[0].runtime;
                count_nxt    = count_r - 1'b1;
              end
            end
            vroq_pkg::FUNC_NONE: begin
            end
          endcase
        end
      end
      vroq_pkg::FSM_SEARCH: begin
        if (hit_any) begin
          cmd.op         = vroq_pkg::CMD_DELETE;
          out_valid_nxt  = 1'b1;
          out_task_nxt   = task_r;
          out_rt_nxt     = hit_rt;
          out_status_nxt = vroq_pkg::STAT_OK;
          count_nxt      = count_r - 1'b1;
          state_nxt      = vroq_pkg::FSM_IDLE;
        end else if (miss_any || !tok_any) begin
          cmd.op         = vroq_pkg::CMD_ABORT;
          out_valid_nxt  = 1'b1;
          out_task_nxt   = task_r;
          out_rt_nxt     = '0;
          out_status_nxt = vroq_pkg::STAT_NOT_FOUND;
          state_nxt      = vroq_pkg::FSM_IDLE;
        end else begin
          cmd.op = vroq_pkg::CMD_SCAN;
        end
      end
    endcase
    count_wide    = (CNT_W + vroq_pkg::COUNT_W)'(count_nxt);
    out_count_nxt = count_wide[vroq_pkg::COUNT_W-1:0];
    if (!out_valid_nxt || out_valid_r && !out_ready) begin
      out_count_nxt = out_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vroq_pkg::FSM_IDLE;
      count_r     <= '0;
      idle_r      <= vroq_pkg::IDLE_ID_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        idle_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    task_r       <= task_nxt;
    out_task_r   <= out_task_nxt;
    out_rt_r     <= out_rt_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_task_out    = out_task_r;
  assign out_runtime_out = out_rt_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;

  `VQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `VQ_ASSERT_SAME(a_valid_count, 1'b1, CNT_W'($countones(valid_v)) == count_r, "valid slots differ from count")
  `VQ_ASSERT_SAME(a_token_single, state_r == vroq_pkg::FSM_SEARCH, $onehot0(tok_v), "more than one search token")
  `VQ_ASSERT_SAME(a_search_no_out, state_r == vroq_pkg::FSM_SEARCH, !out_valid_r, "result pending during search")
  `VQ_ASSERT_NEXT(a_remove_search, accept && in_func == vroq_pkg::FUNC_REMOVE, state_r == vroq_pkg::FSM_SEARCH, "remove did not start a search")

endmodule
